FILE: rtl/rrn_pkg.sv
// rrn_pkg: shared types, constants and register codes for the row rms normalizer
// used by rrn_ctrl, rrn_dp and row_rms_normalizer
package rrn_pkg;

    localparam int LANES       = 4;
    localparam int LANE_SH     = $clog2(LANES);
    localparam int DW          = 16;
    localparam int LEN_W       = 9;
    localparam int EPS_W       = 32;
    localparam int SUM_W       = 40;
    localparam int VN_W        = 62;
    localparam int R_W         = 32;
    localparam int T_W         = 34;
    localparam int SH_W        = 5;
    localparam int GRP_W       = 7;
    localparam int CNT_W       = 6;
    localparam int MAX_ROW_DEF = 256;
    localparam int NEWTON_DEF  = 4;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_LEN    = 2'd0;
    localparam logic [1:0] REG_EPSILON    = 2'd1;
    localparam logic [1:0] REG_USE_WEIGHT = 2'd2;

    localparam logic [LEN_W-1:0] ROW_LEN_RST = 9'd128;
    localparam logic [EPS_W-1:0] EPS_RST     = 32'd1;

    // newton phases
    localparam logic [1:0] PH_SQ  = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_UPD = 2'd2;

    // start values of r in Q2.30: 1.75 and about 1.2
    localparam logic [R_W-1:0] R_INIT_LO = 32'd1879048192;
    localparam logic [R_W-1:0] R_INIT_HI = 32'd1288490189;
    localparam logic [T_W-1:0] THREE_Q30 = 34'h0C0000000;

    typedef logic [LANES-1:0] t_lane_mask;

    typedef struct packed {
        logic signed [DW-1:0] x0;
        logic signed [DW-1:0] x1;
        logic signed [DW-1:0] x2;
        logic signed [DW-1:0] x3;
        logic signed [DW-1:0] w0;
        logic signed [DW-1:0] w1;
        logic signed [DW-1:0] w2;
        logic signed [DW-1:0] w3;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] y0;
        logic signed [DW-1:0] y1;
        logic signed [DW-1:0] y2;
        logic signed [DW-1:0] y3;
        logic                 row_end;
    } t_out_item;

    typedef struct packed {
        logic              load;
        t_lane_mask        lane_en;
        logic [GRP_W-1:0]  wr_grp;
        logic              sum_clr;
        logic              div_init;
        logic              div_step;
        logic              norm_init;
        logic              norm_step;
        logic              newt_init;
        logic              newt_go;
        logic [1:0]        newt_ph;
        logic              rd;
        logic [GRP_W-1:0]  rd_grp;
        t_lane_mask        rd_mask;
        logic              rd_last;
        logic [LEN_W-1:0]  len;
        logic [EPS_W-1:0]  eps;
        logic              use_w;
    } t_dp_cmd;

    typedef struct packed {
        logic norm_done;
        logic inf;
        logic pipe_busy;
    } t_dp_stat;

endpackage

FILE: rtl/rrn_ctrl.sv
// rrn_ctrl: configuration registers, row fill counter and sequencing fsm
// depends on rrn_pkg
module rrn_ctrl import rrn_pkg::*; #(
    parameter int MAX_ROW      = MAX_ROW_DEF,
    parameter int NEWTON_STEPS = NEWTON_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [EPS_W-1:0] i_cfg_data,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    localparam int SW = $clog2(NEWTON_STEPS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_NORM  = 6'b000100,
        S_NEWT  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_row_len;
    logic [EPS_W-1:0] r_eps;
    logic             r_use_w;
    logic [LEN_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]    r_step, n_step;
    logic [1:0]       r_ph, n_ph;
    logic [GRP_W-1:0] r_grp, n_grp;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] groups;
    logic             acc;
    logic             complete;
    logic             cfg_wr;
    logic             last_grp;
    t_lane_mask       lane_en;
    t_lane_mask       rd_mask;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign busy        = (r_state != S_IDLE);
    assign acc         = start && (r_state == S_IDLE);

    always_comb begin
        if (r_row_len == '0) begin
            len = LEN_W'(1);
        end else if (r_row_len > LEN_W'(MAX_ROW)) begin
            len = LEN_W'(MAX_ROW);
        end else begin
            len = r_row_len;
        end
    end

    assign groups   = LEN_W'((len + LEN_W'(LANES - 1)) >> LANE_SH);
    assign complete = ({1'b0, r_count} + (LEN_W+1)'(LANES)) >= {1'b0, len};
    assign last_grp = (LEN_W'(r_grp) + LEN_W'(1)) == groups;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            lane_en[j] = ({1'b0, r_count} + (LEN_W+1)'(j)) < {1'b0, len};
            rd_mask[j] = (((LEN_W+1)'(r_grp) << LANE_SH) + (LEN_W+1)'(j)) < {1'b0, len};
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_ph    = r_ph;
        n_grp   = r_grp;
        o_cmd   = '0;
        o_cmd.len     = len;
        o_cmd.eps     = r_eps;
        o_cmd.use_w   = r_use_w;
        o_cmd.lane_en = lane_en;
        o_cmd.wr_grp  = GRP_W'(r_count >> LANE_SH);
        o_cmd.newt_ph = r_ph;
        o_cmd.rd_grp  = r_grp;
        o_cmd.rd_mask = rd_mask;
        o_cmd.rd_last = last_grp;

        if (cfg_wr && i_cfg_index == REG_ROW_LEN) begin
            n_count       = '0;
            o_cmd.sum_clr = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.load = 1'b1;
                    if (complete) begin
                        n_count = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_count = r_count + LEN_W'(LANES);
                    end
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == CNT_W'(SUM_W)) begin
                        n_cnt   = '0;
                        n_state = S_NORM;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_NORM: begin
                if (r_cnt == '0) begin
                    o_cmd.norm_init = 1'b1;
                    n_cnt = CNT_W'(1);
                end else if (i_stat.inf) begin
                    n_grp   = '0;
                    n_state = S_DRAIN;
                end else if (i_stat.norm_done) begin
                    n_cnt   = '0;
                    n_state = S_NEWT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_NEWT: begin
                if (r_cnt == '0) begin
                    o_cmd.newt_init = 1'b1;
                    n_cnt  = CNT_W'(1);
                    n_step = '0;
                    n_ph   = PH_SQ;
                end else if (r_step == SW'(NEWTON_STEPS)) begin
                    n_grp   = '0;
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.newt_go = 1'b1;
                    if (r_ph == PH_UPD) begin
                        n_ph   = PH_SQ;
                        n_step = r_step + SW'(1);
                    end else begin
                        n_ph = r_ph + 2'd1;
                    end
                end
            end
            S_DRAIN: begin
                o_cmd.rd = 1'b1;
                n_grp    = r_grp + GRP_W'(1);
                if (last_grp) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_len <= ROW_LEN_RST;
            r_eps     <= EPS_RST;
            r_use_w   <= 1'b1;
            r_count   <= '0;
            r_cnt     <= '0;
            r_step    <= '0;
            r_ph      <= PH_SQ;
            r_grp     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_ph    <= n_ph;
            r_grp   <= n_grp;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_ROW_LEN:    r_row_len <= i_cfg_data[LEN_W-1:0];
                    REG_EPSILON:    r_eps     <= i_cfg_data;
                    REG_USE_WEIGHT: r_use_w   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < len))
        else $error("partial row count reached row length");
    a_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && complete) |=> (r_state == S_DIV))
        else $error("completed row did not start the division");
    a_drain_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (LEN_W'(r_grp) < groups))
        else $error("drain read past the last group");
    a_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.pipe_busy)
        else $error("scale pipeline busy while idle");
`endif

endmodule

FILE: rtl/rrn_dp.sv
// rrn_dp: row store, square sum, divider, normalizer, newton unit and scale pipeline
// depends on rrn_pkg
module rrn_dp import rrn_pkg::*; #(
    parameter int MAX_ROW = MAX_ROW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int NG = (MAX_ROW + LANES - 1) / LANES;
    localparam int AW = (NG > 1) ? $clog2(NG) : 1;

    t_in_item mem [NG];

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_dvd;
    logic [LEN_W:0]   r_rem;
    logic [VN_W-1:0]  r_vn;
    logic [SH_W-1:0]  r_s;
    logic             r_inf;
    logic [R_W-1:0]   r_r;
    logic [R_W-1:0]   r_mm;
    logic [T_W-1:0]   r_t;
    logic [R_W-1:0]   r_d;

    logic [SUM_W-1:0] sq_tot;
    logic [DW-1:0]    xin [LANES];
    logic [LEN_W:0]   rem2;
    logic             ge;
    logic [SUM_W-1:0] vsum;
    logic [63:0]      p_sq;
    logic [65:0]      p_mul;
    logic [T_W-1:0]   u;
    logic [63:0]      p_upd;

    // scale pipeline
    logic             r_a_v, r_a_last;
    t_lane_mask       r_a_mask;
    t_in_item         r_a_item;
    logic             r_b_v, r_b_last;
    logic signed [31:0] r_b_p [LANES];
    logic             r_c_v, r_c_last;
    logic [62:0]      r_c_prod [LANES];
    logic [LANES-1:0] r_c_neg, r_c_zero;
    logic             r_d_v, r_d_last;
    logic [DW-1:0]    r_d_y [LANES];

    logic [DW-1:0]    ax [LANES];
    logic [DW-1:0]    aw [LANES];
    logic [5:0]       sh;

    assign xin[0] = i_in.x0;
    assign xin[1] = i_in.x1;
    assign xin[2] = i_in.x2;
    assign xin[3] = i_in.x3;
    assign ax[0]  = r_a_item.x0;
    assign ax[1]  = r_a_item.x1;
    assign ax[2]  = r_a_item.x2;
    assign ax[3]  = r_a_item.x3;
    assign aw[0]  = r_a_item.w0;
    assign aw[1]  = r_a_item.w1;
    assign aw[2]  = r_a_item.w2;
    assign aw[3]  = r_a_item.w3;

    always_comb begin
        logic signed [31:0] sq;
        sq_tot = '0;
        for (int j = 0; j < LANES; j++) begin
            sq = $signed(xin[j]) * $signed(xin[j]);
            if (i_cmd.lane_en[j]) begin
                sq_tot = sq_tot + SUM_W'($unsigned(sq));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[i_cmd.wr_grp[AW-1:0]] <= i_in;
        end
        if (i_cmd.rd) begin
            r_a_item <= mem[i_cmd.rd_grp[AW-1:0]];
        end
    end

    // restoring divide, one quotient bit per cycle
    assign rem2 = {r_rem[LEN_W-1:0], r_dvd[SUM_W-1]};
    assign ge   = rem2 >= {1'b0, i_cmd.len};
    assign vsum = r_dvd + SUM_W'(i_cmd.eps);

    assign p_sq  = r_r * r_r;
    assign p_mul = r_t * r_mm;
    assign u     = p_mul[65:32];
    assign p_upd = r_r * r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.sum_clr || i_cmd.div_init) begin
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_sum <= r_sum + sq_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dvd <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? (rem2 - {1'b0, i_cmd.len}) : rem2;
            r_dvd <= {r_dvd[SUM_W-2:0], ge};
        end
        if (i_cmd.norm_init) begin
            r_vn  <= VN_W'(vsum);
            r_inf <= (vsum == '0);
            r_s   <= '0;
        end else if (i_cmd.norm_step) begin
            r_vn <= r_vn << 2;
            r_s  <= r_s + SH_W'(1);
        end
        if (i_cmd.newt_init) begin
            r_mm <= r_vn[VN_W-1:VN_W-R_W];
            r_r  <= r_vn[VN_W-1] ? R_INIT_HI : R_INIT_LO;
        end else if (i_cmd.newt_go) begin
            case (i_cmd.newt_ph)
                PH_SQ:  r_t <= p_sq[63:30];
                PH_MUL: r_d <= (u >= THREE_Q30) ? '0 : R_W'(THREE_Q30 - u);
                PH_UPD: r_r <= p_upd[62:31];
                default: ;
            endcase
        end
    end

    assign o_stat.norm_done = |r_vn[VN_W-1:VN_W-2];
    assign o_stat.inf       = r_inf;
    assign o_stat.pipe_busy = r_a_v || r_b_v || r_c_v;

    assign sh = 6'd61 - 6'(r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_cmd.rd;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] p;
        logic [30:0]        mag;
        logic [63:0]        rsum;
        logic [63:0]        q;
        r_a_mask <= i_cmd.rd_mask;
        r_a_last <= i_cmd.rd_last;
        r_b_last <= r_a_last;
        r_c_last <= r_b_last;
        r_d_last <= r_c_last;
        for (int j = 0; j < LANES; j++) begin
            // stage b: element times weight, or times one in Q7.8
            if (!r_a_mask[j]) begin
                r_b_p[j] <= '0;
            end else if (i_cmd.use_w) begin
                r_b_p[j] <= $signed(ax[j]) * $signed(aw[j]);
            end else begin
                r_b_p[j] <= 32'($signed(ax[j])) <<< 8;
            end
            // stage c: magnitude times factor
            p   = r_b_p[j];
            mag = (p < 0) ? 31'(-p) : 31'(p);
            r_c_neg[j]  <= (p < 0);
            r_c_zero[j] <= (p == 0);
            r_c_prod[j] <= 63'(mag) * 63'(r_r);
            // stage d: round half away, shift, saturate
            rsum = {1'b0, r_c_prod[j]} + (64'(1) << (sh - 6'd1));
            q    = rsum >> sh;
            if (r_c_zero[j]) begin
                r_d_y[j] <= '0;
            end else if (r_inf) begin
                r_d_y[j] <= r_c_neg[j] ? 16'h8000 : 16'h7FFF;
            end else if (r_c_neg[j]) begin
                r_d_y[j] <= (q > 64'd32768) ? 16'h8000 : 16'(64'd0 - q);
            end else begin
                r_d_y[j] <= (q > 64'd32767) ? 16'h7FFF : q[DW-1:0];
            end
        end
    end

    assign o_valid          = r_d_v;
    assign o_result.y0      = r_d_y[0];
    assign o_result.y1      = r_d_y[1];
    assign o_result.y2      = r_d_y[2];
    assign o_result.y3      = r_d_y[3];
    assign o_result.row_end = r_d_last;

endmodule

FILE: rtl/row_rms_normalizer.sv
// row_rms_normalizer: top level, joins the sequencer and the datapath
// depends on rrn_pkg, rrn_ctrl, rrn_dp
//
// One group of four elements and weights is taken per cycle while busy is low. The group
// that completes a row raises busy; the block then divides the square sum by the row
// length bit by bit, normalizes the mean plus epsilon two bits per step, runs
// NEWTON_STEPS newton steps through three registered multiplies each (skipped when the
// mean plus epsilon is zero, which saturates the nonzero results), and reads the row store
// one group per cycle into a four stage scale pipeline. Results leave one group per cycle
// with o_result_valid high for that single cycle and row_end on the last group; the receiver
// must take them as they come. busy falls only after the last group has been shown in
// the output register.
module row_rms_normalizer import rrn_pkg::*; #(
    parameter int MAX_ROW      = MAX_ROW_DEF,
    parameter int NEWTON_STEPS = NEWTON_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_in,
    output logic             o_result_valid,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [EPS_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rrn_ctrl #(
        .MAX_ROW      (MAX_ROW),
        .NEWTON_STEPS (NEWTON_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rrn_dp #(
        .MAX_ROW (MAX_ROW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

endmodule

FILE: sim/rrn_checker.sv
`timescale 1ns / 100ps
// rrn_checker: watches the config, group and result channels of row_rms_normalizer,
// predicts each normalized row and compares it lane by lane; depends on rrn_pkg
module rrn_checker import rrn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_in_item         i_in,
    input  logic             i_result_valid,
    input  t_out_item        i_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [EPS_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int ROW_CAP = 256;

    logic [DW-1:0]    elem_mem [ROW_CAP];
    logic [DW-1:0]    wgt_mem  [ROW_CAP];
    logic [63:0]      sq_sum;
    int unsigned      elem_cnt;
    logic [LEN_W-1:0] len_reg;
    logic [EPS_W-1:0] eps_reg;
    logic             use_w_reg;
    t_out_item        expected_groups [$];

    assign o_pending = expected_groups.size();

    function automatic int unsigned active_len();
        if (len_reg == '0) return 1;
        if (len_reg > ROW_CAP) return ROW_CAP;
        return len_reg;
    endfunction

    function automatic logic [DW-1:0] scale_lane(longint signed p, bit inf,
                                                 logic [63:0] r, int unsigned s);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] q;
        int unsigned sh;
        neg = p < 0;
        mag = neg ? 64'(-p) : 64'(p);
        if (mag == 0) return '0;
        if (inf) begin
            q = neg ? 64'd32768 : 64'd32767;
        end else begin
            sh = 61 - s;
            q = (mag * r + (64'd1 << (sh - 1))) >> sh;
        end
        if (neg) begin
            if (q > 32768) q = 32768;
            return DW'(64'd0 - q);
        end
        if (q > 32767) q = 32767;
        return DW'(q);
    endfunction

    // mean square, reciprocal square root, then one expectation per group
    task automatic predict_row(int unsigned len);
        logic [63:0]       v;
        logic [63:0]       vn;
        logic [63:0]       mm;
        logic [63:0]       r;
        logic [63:0]       t;
        logic [63:0]       u;
        logic [63:0]       d;
        int unsigned       s;
        int unsigned       idx;
        bit                inf;
        longint signed     x;
        longint signed     p;
        logic [DW-1:0]     y [LANES];
        t_out_item         grp;
        v = sq_sum / len + 64'(eps_reg);
        inf = (v == 0);
        r = 0;
        s = 0;
        if (!inf) begin
            vn = v;
            while (vn < (64'd1 << 60)) begin
                vn = vn << 2;
                s++;
            end
            mm = vn >> 30;
            r = (vn < (64'd1 << 61)) ? 64'(R_INIT_LO) : 64'(R_INIT_HI);
            for (int k = 0; k < NEWTON_DEF; k++) begin
                t = (r * r) >> 30;
                u = (t * mm) >> 32;
                d = (u >= 64'(THREE_Q30)) ? 64'd0 : 64'(THREE_Q30) - u;
                r = (r * d) >> 31;
            end
        end
        for (int g = 0; g < (len + LANES - 1) / LANES; g++) begin
            for (int j = 0; j < LANES; j++) begin
                idx = g * LANES + j;
                if (idx >= len) begin
                    y[j] = '0;
                end else begin
                    x = longint'(signed'(elem_mem[idx]));
                    p = use_w_reg ? x * longint'(signed'(wgt_mem[idx])) : x * 256;
                    y[j] = scale_lane(p, inf, r, s);
                end
            end
            grp.y0 = y[0];
            grp.y1 = y[1];
            grp.y2 = y[2];
            grp.y3 = y[3];
            grp.row_end = ((g + 1) * LANES >= len);
            expected_groups.push_back(grp);
        end
    endtask

    task automatic absorb_group(t_in_item it);
        logic [DW-1:0]  xs [LANES];
        logic [DW-1:0]  ws [LANES];
        longint signed  x;
        int unsigned    len;
        len = active_len();
        xs = '{it.x0, it.x1, it.x2, it.x3};
        ws = '{it.w0, it.w1, it.w2, it.w3};
        for (int j = 0; j < LANES; j++) begin
            if (elem_cnt < len) begin
                x = longint'(signed'(xs[j]));
                elem_mem[elem_cnt] = xs[j];
                wgt_mem[elem_cnt]  = ws[j];
                sq_sum += 64'(x * x);
                elem_cnt++;
            end
        end
        if (elem_cnt >= len) begin
            predict_row(len);
            elem_cnt = 0;
            sq_sum = 0;
        end
    endtask

    task automatic note_mismatch(string field, int exp_v, int act_v);
        if (o_fail_count < 10)
            $display("mismatch %s: expected %0d got %0d at %0t", field, exp_v, act_v, $realtime);
        o_fail_count++;
    endtask

    task automatic check_group(t_out_item got);
        t_out_item want;
        if (expected_groups.size() == 0) begin
            if (o_fail_count < 10)
                $display("unexpected result transaction at %0t", $realtime);
            o_fail_count++;
            return;
        end
        want = expected_groups.pop_front();
        if (got.y0 !== want.y0) note_mismatch("y0", want.y0, got.y0);
        if (got.y1 !== want.y1) note_mismatch("y1", want.y1, got.y1);
        if (got.y2 !== want.y2) note_mismatch("y2", want.y2, got.y2);
        if (got.y3 !== want.y3) note_mismatch("y3", want.y3, got.y3);
        if (got.row_end !== want.row_end) note_mismatch("row_end", want.row_end, got.row_end);
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_sum    <= '0;
            elem_cnt  <= 0;
            len_reg   <= ROW_LEN_RST;
            eps_reg   <= EPS_RST;
            use_w_reg <= 1'b1;
            expected_groups.delete();
        end else begin
            if (i_result_valid === 1'b1) check_group(i_result);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW_LEN: begin
                        len_reg  = i_cfg_data[LEN_W-1:0];
                        elem_cnt = 0;
                        sq_sum   = 0;
                    end
                    REG_EPSILON:    eps_reg = i_cfg_data;
                    REG_USE_WEIGHT: use_w_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) absorb_group(i_in);
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// testbench: drives rows of element groups and register writes into row_rms_normalizer
// with random gaps; rrn_checker predicts and compares; depends on rrn_pkg and the rtl
module testbench;
    import rrn_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_in;
    logic             o_result_valid;
    t_out_item        o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [EPS_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending_groups;
    int               cycle_cnt;
    bit               no_gaps;
    int               groups_sent;

    row_rms_normalizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rrn_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_in           (i_in),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_groups)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("row_rms_normalizer verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // start stays high across back-to-back groups
    task automatic push_group(t_in_item it);
        bit taken;
        int gap;
        start <= 1'b1;
        i_in  <= it;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        groups_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_groups != 0 || busy);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [EPS_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_group(logic signed [DW-1:0] xa, logic signed [DW-1:0] xb,
                                            logic signed [DW-1:0] xc, logic signed [DW-1:0] xd,
                                            logic signed [DW-1:0] wa, logic signed [DW-1:0] wb,
                                            logic signed [DW-1:0] wc, logic signed [DW-1:0] wd);
        t_in_item it;
        it = '{xa, xb, xc, xd, wa, wb, wc, wd};
        return it;
    endfunction

    function automatic logic [DW-1:0] rand_field(int mode);
        case (mode)
            0: return DW'($urandom);
            1: return DW'($urandom_range(1023)) - 16'd512;
            default: return ($urandom_range(3) == 0) ? DW'($urandom) : '0;
        endcase
    endfunction

    function automatic t_in_item rand_group();
        t_in_item it;
        int       roll;
        int       mode;
        roll = $urandom_range(99);
        mode = (roll < 60) ? 0 : (roll < 85) ? 1 : 2;
        it = '{rand_field(mode), rand_field(mode), rand_field(mode), rand_field(mode),
               rand_field(mode), rand_field(mode), rand_field(mode), rand_field(mode)};
        return it;
    endfunction

    function automatic int unsigned rand_row_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75) return $urandom_range(12, 1);
        if (roll < 92) return $urandom_range(40, 13);
        return $urandom_range(160, 41);
    endfunction

    function automatic logic [EPS_W-1:0] rand_eps();
        case ($urandom_range(4))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned len;
        int unsigned eff;
        int          rows;
        cycle_cnt   = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ROW_LEN;
        i_cfg_data  = '0;
        no_gaps     = 1'b0;
        groups_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the fields, weighted
        write_reg(REG_ROW_LEN, 32'd4);
        write_reg(REG_EPSILON, 32'd1);
        write_reg(REG_USE_WEIGHT, 32'd1);
        push_group(make_group(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        push_group(make_group(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        push_group(make_group(32767, -32768, 1, -1, -32768, 32767, -1, 256));
        push_group(make_group(0, 0, 0, 0, 100, -100, 5, 7));
        settle();
        // zero epsilon: zero row and an infinite factor from a tiny row
        write_reg(REG_EPSILON, 32'd0);
        push_group(make_group(0, 0, 0, 0, 1, 2, 3, 4));
        push_group(make_group(1, -1, 0, 0, 256, 256, 256, 256));
        push_group(make_group(-300, 400, 5, -6, 256, -512, 9, 1));
        settle();
        // row length zero acts as one, no weights
        write_reg(REG_ROW_LEN, 32'd0);
        write_reg(REG_USE_WEIGHT, 32'd0);
        push_group(make_group(-32768, 5, 6, 7, 0, 0, 0, 0));
        push_group(make_group(32767, -5, -6, -7, 1, 1, 1, 1));
        settle();
        // lanes past the row end
        write_reg(REG_ROW_LEN, 32'd5);
        write_reg(REG_EPSILON, '1);
        push_group(make_group(1000, -2000, 3000, -4000, 1, 1, 1, 1));
        push_group(make_group(500, 32767, -32768, 12, 1, 1, 1, 1));
        settle();
        // partial row dropped by a row length write
        write_reg(REG_ROW_LEN, 32'd7);
        write_reg(REG_USE_WEIGHT, 32'd1);
        push_group(make_group(9000, 9000, 9000, 9000, 256, 256, 256, 256));
        settle();
        write_reg(REG_ROW_LEN, 32'd3);
        write_reg(REG_EPSILON, 32'd65536);
        push_group(make_group(256, -512, 768, 1024, 256, 512, -768, 300));
        settle();

        rows = 0;
        while (groups_sent < 140) begin
            no_gaps = ($urandom_range(3) == 0);
            // one row above the maximum length, clamped to a full store
            if (rows == 2) len = 400;
            else len = rand_row_len();
            write_reg(REG_ROW_LEN, len);
            write_reg(REG_EPSILON, rand_eps());
            write_reg(REG_USE_WEIGHT, $urandom_range(1));
            eff = (len == 0) ? 1 : (len > 256) ? 256 : len;
            repeat ((eff > 40) ? 1 : $urandom_range(3, 1)) begin
                for (int g = 0; g < (eff + LANES - 1) / LANES; g++) push_group(rand_group());
            end
            // occasionally leave a broken row behind before the next setting
            if ($urandom_range(4) == 0 && eff > LANES) push_group(rand_group());
            rows++;
            settle();
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending_groups != 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("row_rms_normalizer verification clean");
        else
            $display("row_rms_normalizer verification failed");
        $finish;
    end

endmodule
